// ----- rtl/core/cmfp_pkg.sv -----
package cmfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CrcW  = 32;
  localparam int unsigned CntW  = 3;

  localparam logic [CrcW-1:0] CrcPoly   = 32'h04C1_1DB7;
  localparam logic [CntW-1:0] CntLoaded = 3'd4;

  // One byte request as it travels from the input register to the engine.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } byte_req_t;

  // Remainder of (top << 24) after eight MSB-first division steps.
  function automatic logic [CrcW-1:0] crc_table_word(input logic [ByteW-1:0] top);
    logic [CrcW-1:0] r;
    r = {top, {(CrcW-ByteW){1'b0}}};
    for (int k = 0; k < ByteW; k++) begin
      if (r[CrcW-1]) begin
        r = {r[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[CrcW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/cmfp_in_reg.sv -----
module cmfp_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               in_stall,
  input  logic               take,
  output logic               req_valid,
  output cmfp_pkg::byte_req_t req
);
  import cmfp_pkg::*;

  logic      req_valid_r;
  byte_req_t req_r;

  // Hold the request while the engine cannot take it.
  assign in_stall = req_valid_r && !take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (!in_stall) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_r.data_byte <= in_data_byte;
      req_r.last_byte <= in_last_byte;
    end
  end

  assign req_valid = req_valid_r;
  assign req       = req_r;

endmodule

// ----- rtl/core/cmfp_engine.sv -----
module cmfp_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  input  cmfp_pkg::byte_req_t req,
  output logic                take,
  output logic                out_valid,
  output logic [31:0]         out_hash_value,
  input  logic                out_stall
);
  import cmfp_pkg::*;

  logic [CrcW-1:0] crc_r, crc_nxt, crc_upd;
  logic [CntW-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic            out_valid_r, out_valid_nxt;
  logic [CrcW-1:0] hash_r, hash_upd;
  logic            out_free, fire;

  assign out_free = !out_valid_r || !out_stall;
  // A byte that finishes no message never needs the output slot.
  assign take     = !req.last_byte || out_free;
  assign fire     = req_valid && take;

  always_comb begin
    crc_upd = crc_r;
    cnt_upd = cnt_r;
    if (cnt_r < CntLoaded) begin
      unique case (cnt_r[1:0])
        2'd0:    crc_upd = crc_r | {req.data_byte, 24'h0};
        2'd1:    crc_upd = crc_r | {8'h0, req.data_byte, 16'h0};
        2'd2:    crc_upd = crc_r | {16'h0, req.data_byte, 8'h0};
        default: crc_upd = ~(crc_r | {24'h0, req.data_byte});
      endcase
      cnt_upd = cnt_r + 3'd1;
    end else begin
      crc_upd = {crc_r[CrcW-ByteW-1:0], req.data_byte}
                ^ crc_table_word(crc_r[CrcW-1:CrcW-ByteW]);
    end
    hash_upd = (cnt_upd >= CntLoaded) ? ~crc_upd : crc_upd;
  end

  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    if (fire) begin
      if (req.last_byte) begin
        crc_nxt = '0;
        cnt_nxt = '0;
      end else begin
        crc_nxt = crc_upd;
        cnt_nxt = cnt_upd;
      end
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (fire && req.last_byte) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && req.last_byte) begin
      hash_r <= hash_upd;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = hash_r;

endmodule

// ----- rtl/core/crc32_msb_first_preloaded.sv -----
// Channel   Direction  Handshake           Payload
// in_       request    in_valid/in_stall   in_data_byte[7:0], in_last_byte
// out_      result     out_valid/out_stall out_hash_value[31:0]
//
// One byte request is taken every cycle unless a last byte waits for the output slot; a
// result leaves through the input register and then the result register, around the
// combinational shift/table/XOR update.
// Reset (rst_n low, synchronous) clears the CRC state and both valid flags.
// out_stall holds the result; a last byte then waits in the input register,
// while other bytes keep flowing through the update.
module crc32_msb_first_preloaded (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        in_stall,
  output logic        out_valid,
  output logic [31:0] out_hash_value,
  input  logic        out_stall
);
  import cmfp_pkg::*;

  logic      req_valid;
  logic      take;
  byte_req_t req;

  // Register the incoming request.
  cmfp_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .take         (take),
    .req_valid    (req_valid),
    .req          (req)
  );

  // Pack the first four bytes, then advance the CRC one byte per request,
  // and register the hash when the message ends.
  cmfp_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_valid),
    .req            (req),
    .take           (take),
    .out_valid      (out_valid),
    .out_hash_value (out_hash_value),
    .out_stall      (out_stall)
  );

endmodule

// ----- tb/crc32_msb_first_preloaded_test.sv -----
module crc32_msb_first_preloaded_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cmfp_pkg::*;

  // Directed request: a byte, its last flag, and optionally a hash that is
  // obvious by inspection (short or four-byte messages return packed bytes).
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             typed;
    logic [CrcW-1:0]  hash;
  } stim_row_t;

  localparam int NumDirected = 25;
  localparam int PhaseBytes  = 250;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic [ByteW-1:0] in_data_byte;
  logic             in_last_byte;
  logic             in_stall;
  logic             out_valid;
  logic [CrcW-1:0]  out_hash_value;
  logic             out_stall;

  // Predictor state: running CRC word and how many leading bytes were packed.
  logic [CrcW-1:0]  crc_acc;
  logic [CntW-1:0]  fill_count;

  logic [CrcW-1:0]  hash_expect_q[$];
  int unsigned      error_count;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;

  stim_row_t directed_rows [NumDirected] = '{
    // single byte, both extremes
    '{8'h00, 1'b1, 1'b1, 32'h0},
    '{8'hFF, 1'b1, 1'b1, 32'hFF00_0000},
    // two and three bytes: packed, zero filled, never inverted
    '{8'hA5, 1'b0, 1'b0, 32'h0},
    '{8'h5A, 1'b1, 1'b1, 32'hA55A_0000},
    '{8'h01, 1'b0, 1'b0, 32'h0},
    '{8'h02, 1'b0, 1'b0, 32'h0},
    '{8'h03, 1'b1, 1'b1, 32'h0102_0300},
    // exactly four bytes: the two inversions cancel
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    // five bytes: first table update
    '{8'h12, 1'b0, 1'b0, 32'h0},
    '{8'h34, 1'b0, 1'b0, 32'h0},
    '{8'h56, 1'b0, 1'b0, 32'h0},
    '{8'h78, 1'b0, 1'b0, 32'h0},
    '{8'h9A, 1'b1, 1'b0, 32'h0},
    // six all-ones bytes: the packed word inverts to zero, then two table updates
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b1, 1'b0, 32'h0},
    // three bytes again, after a long message
    '{8'h80, 1'b0, 1'b0, 32'h0},
    '{8'h7F, 1'b0, 1'b0, 32'h0},
    '{8'h01, 1'b1, 1'b1, 32'h807F_0100}
  };

  crc32_msb_first_preloaded dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_hash_value (out_hash_value),
    .out_stall      (out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a clean run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Remainder of (top << 24) modulo the polynomial, one bit per step.
  function automatic logic [CrcW-1:0] poly_remainder(input logic [ByteW-1:0] top);
    logic [CrcW-1:0] rem;
    logic            carry;
    rem = CrcW'(top) << (CrcW - ByteW);
    repeat (ByteW) begin
      carry = rem[CrcW-1];
      rem   = rem << 1;
      if (carry) rem = rem ^ CrcPoly;
    end
    return rem;
  endfunction

  // Fold one byte into the predicted state; return 1 with the hash on a last byte.
  function automatic bit absorb_byte(input logic [ByteW-1:0] b, input logic last,
                                     output logic [CrcW-1:0] hash);
    hash = '0;
    if (fill_count < CntLoaded) begin
      crc_acc    = crc_acc | (CrcW'(b) << (CrcW - ByteW - ByteW * fill_count));
      fill_count = fill_count + 1'b1;
      if (fill_count == CntLoaded) crc_acc = ~crc_acc;
    end else begin
      crc_acc = {crc_acc[CrcW-ByteW-1:0], b} ^ poly_remainder(crc_acc[CrcW-1 -: ByteW]);
    end
    if (!last) return 1'b0;
    hash       = (fill_count >= CntLoaded) ? ~crc_acc : crc_acc;
    crc_acc    = '0;
    fill_count = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [CrcW-1:0] got,
                                 input logic [CrcW-1:0] want);
    $display("%0t ns: %s: got %08h, want %08h", $realtime, what, got, want);
    error_count++;
  endtask

  // Send one byte request: idle at random first, then hold it until taken.
  // A typed hash, where given, replaces the predicted one as the expectation.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last,
                           input logic typed, input logic [CrcW-1:0] typed_hash);
    logic [CrcW-1:0] hash;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid     <= 1'b0;
      in_data_byte <= 8'($urandom);
      in_last_byte <= 1'($urandom);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    if (absorb_byte(b, last, hash)) hash_expect_q.push_back(typed ? typed_hash : hash);
  endtask

  // Random message: mostly short ones around the packing boundary, a few long.
  task automatic send_message(output int unsigned len);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      len = $urandom_range(1, 5);
    else if (pick < 85) len = $urandom_range(6, 16);
    else                len = $urandom_range(17, 48);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom), i == len - 1, 1'b0, '0);
    end
  endtask

  // Drop valid and hold the sender until every pending hash has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (hash_expect_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall at random, redrawn at every falling edge; low in reset.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Result checker: compare every accepted hash with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (hash_expect_q.size() == 0) begin
        report_mismatch("unexpected hash", out_hash_value, '0);
      end else begin
        if (out_hash_value !== hash_expect_q[0]) begin
          report_mismatch("hash_value", out_hash_value, hash_expect_q[0]);
        end
        void'(hash_expect_q.pop_front());
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned msg_len;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = '0;
    in_last_byte   = 1'b0;
    crc_acc        = '0;
    fill_count     = '0;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // Hold reset, then release it away from the sampling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table at full rate on both sides.
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].hash);
    end
    drain_results();

    // Random messages through the four idling mixes; pause for results in between.
    for (int phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      sent = 0;
      while (sent < PhaseBytes) begin
        // Count the phase in bytes sent.
        send_message(msg_len);
        sent = sent + msg_len;
      end
      drain_results();
    end

    // Let the pipeline settle, then report.
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (error_count == 0 && hash_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
